>>> sv/iqdf_pkg.sv
`timescale 1ns / 1ps

package iqdf_pkg;

    // frame layout
    localparam int HEADER_BYTES       = 8;
    localparam int SYNC_BYTES         = 3;
    localparam int GROUP_BYTES        = 8;
    localparam int GROUPS_DEFAULT     = 63;

    localparam logic [7:0] SYNC_RESET = 8'd127;

    // input kinds
    localparam logic IN_DATA_BYTE     = 1'b0;
    localparam logic IN_OVF_READ      = 1'b1;

    // result kinds
    localparam logic [1:0] RES_SAMPLES  = 2'd0;
    localparam logic [1:0] RES_CONTROL  = 2'd1;
    localparam logic [1:0] RES_SYNC_ERR = 2'd2;
    localparam logic [1:0] RES_OVF_READ = 2'd3;

    // control byte zero and one bits
    localparam int C0_PTT_BIT   = 0;
    localparam int C0_DASH_BIT  = 1;
    localparam int C0_POWER_BIT = 2;
    localparam int C1_OVF_BIT   = 0;

    // register map
    localparam logic REG_SYNC_BYTE = 1'b0;

    // result payload: 107 bits of fields, padded to whole bytes
    localparam int OUT_DATA_W = 112;

    typedef struct packed {
        logic [15:0] fwd_power;
        logic [7:0]  interface_version;
        logic [7:0]  exciter_version;
        logic [7:0]  receiver_version;
        logic        adc_overflow;
        logic        dash_key;
        logic        ptt_dot;
        logic [15:0] mic_chan;
        logic [23:0] right_chan;
        logic [23:0] left_chan;
    } t_result;

endpackage

>>> sv/iq_frame_deframer_unit.sv
`timescale 1ns / 1ps

// channel   | port group      | tdata                         | tuser
// ----------+-----------------+-------------------------------+---------------------------
// bytes in  | s_axis_*        | data_byte                     | kind, frame_start
// results   | m_axis_*        | samples, control status       | result_kind
// config    | psel/penable/.. | sync_byte at byte address 0   | -
//
// one byte is taken each clock while s_axis_tready is high; its result lands in the output register the next cycle
// the output register is refilled in the same cycle it is taken, so a byte can be
// taken every cycle as long as the result side keeps up
// after reset the block waits for a byte flagged frame_start; sync byte resets to 127
// while a result is held and not taken, s_axis_tready is low

module iq_frame_deframer_unit
    import iqdf_pkg::*;
#(
    parameter int GROUPS_PER_FRAME = GROUPS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]            s_axis_tuser,   // [0] kind, [1] frame_start

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [23:0] left_chan, [47:24] right_chan, [63:48] mic_chan, [64] ptt_dot,
    // [65] dash_key, [66] adc_overflow, [74:67] receiver_version,
    // [82:75] exciter_version, [90:83] interface_version, [106:91] fwd_power, rest 0
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [1:0]            m_axis_tuser,   // [1:0] result_kind

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int FRAME_BYTES = HEADER_BYTES + GROUP_BYTES * GROUPS_PER_FRAME;
    localparam int POS_W       = $clog2(FRAME_BYTES);
    localparam int FIELD_W     = $bits(t_result);

    localparam logic [POS_W-1:0] POS_SYNC_END = POS_W'(SYNC_BYTES);
    localparam logic [POS_W-1:0] POS_HDR_END  = POS_W'(HEADER_BYTES);
    localparam logic [POS_W-1:0] POS_LAST_HDR = POS_W'(HEADER_BYTES - 1);
    localparam logic [POS_W-1:0] POS_LAST     = POS_W'(FRAME_BYTES - 1);

    // state
    logic [POS_W-1:0] r_pos,      n_pos;
    logic             r_rejected, n_rejected;
    logic             r_ovf,      n_ovf;
    logic [7:0]       r_sync;
    logic [7:0]       r_ctrl [0:3];
    logic             n_ctrl_we;
    logic [55:0]      r_shift,    n_shift;
    logic [7:0]       r_rx_ver,   n_rx_ver;
    logic [7:0]       r_ex_ver,   n_ex_ver;
    logic [7:0]       r_if_ver,   n_if_ver;
    logic [15:0]      r_power,    n_power;

    // result register
    logic             r_m_valid;
    logic [1:0]       r_m_kind;
    t_result          r_m_data;
    logic             n_res_valid;
    logic [1:0]       n_res_kind;
    t_result          n_res_data;

    logic             s_fire;
    logic             cfg_write;
    logic             kind;
    logic             frame_start;
    logic [7:0]       b;
    logic [POS_W-1:0] eff_pos;
    logic             eff_rej;
    logic             c0_power;

    assign kind        = s_axis_tuser[0];
    assign frame_start = s_axis_tuser[1];
    assign b           = s_axis_tdata;

    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_SYNC_BYTE) ? {24'd0, r_sync} : 32'd0;

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_kind;
    assign m_axis_tdata  = {{(OUT_DATA_W - FIELD_W){1'b0}}, r_m_data};

    assign eff_pos  = frame_start ? '0 : r_pos;
    assign eff_rej  = frame_start ? 1'b0 : r_rejected;
    assign c0_power = r_ctrl[0][C0_POWER_BIT];

    always_comb begin
        n_pos       = r_pos;
        n_rejected  = r_rejected;
        n_ovf       = r_ovf;
        n_ctrl_we   = 1'b0;
        n_shift     = r_shift;
        n_rx_ver    = r_rx_ver;
        n_ex_ver    = r_ex_ver;
        n_if_ver    = r_if_ver;
        n_power     = r_power;
        n_res_valid = 1'b0;
        n_res_kind  = RES_SAMPLES;
        n_res_data  = '0;

        case (kind)
            IN_OVF_READ: begin
                n_res_valid             = 1'b1;
                n_res_kind              = RES_OVF_READ;
                n_res_data.adc_overflow = r_ovf;
                n_ovf                   = 1'b0;
            end
            default: begin
                n_pos      = eff_pos;
                n_rejected = eff_rej;
                if (!eff_rej) begin
                    if (eff_pos == POS_LAST) begin
                        n_pos      = '0;
                        n_rejected = 1'b1;
                    end else begin
                        n_pos = eff_pos + 1'b1;
                    end

                    if (eff_pos < POS_SYNC_END) begin
                        if (b != r_sync) begin
                            n_res_valid = 1'b1;
                            n_res_kind  = RES_SYNC_ERR;
                            n_rejected  = 1'b1;
                            n_pos       = '0;
                        end
                    end else if (eff_pos < POS_HDR_END) begin
                        n_ctrl_we = 1'b1;
                        if (eff_pos == POS_LAST_HDR) begin
                            // last control byte arrives live as C4
                            if (!c0_power) begin
                                n_ovf    = r_ovf | r_ctrl[1][C1_OVF_BIT];
                                n_rx_ver = r_ctrl[2];
                            end else begin
                                n_power  = {r_ctrl[1], r_ctrl[2]};
                            end
                            n_ex_ver = r_ctrl[3];
                            n_if_ver = b;

                            n_res_valid                  = 1'b1;
                            n_res_kind                   = RES_CONTROL;
                            n_res_data.ptt_dot           = r_ctrl[0][C0_PTT_BIT];
                            n_res_data.dash_key          = !r_ctrl[0][C0_PTT_BIT]
                                                           && r_ctrl[0][C0_DASH_BIT];
                            n_res_data.adc_overflow      = n_ovf;
                            n_res_data.receiver_version  = n_rx_ver;
                            n_res_data.exciter_version   = n_ex_ver;
                            n_res_data.interface_version = n_if_ver;
                            n_res_data.fwd_power         = n_power;
                        end
                    end else begin
                        // groups start on a multiple of eight, so the low bits give the slot
                        if (eff_pos[2:0] == 3'd7) begin
                            n_res_valid           = 1'b1;
                            n_res_kind            = RES_SAMPLES;
                            n_res_data.left_chan  = r_shift[55:32];
                            n_res_data.right_chan = r_shift[31:8];
                            n_res_data.mic_chan   = {r_shift[7:0], b};
                        end
                        n_shift = {r_shift[47:0], b};
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_rejected <= 1'b1;
            r_ovf      <= 1'b0;
            r_rx_ver   <= '0;
            r_ex_ver   <= '0;
            r_if_ver   <= '0;
            r_power    <= '0;
            r_sync     <= SYNC_RESET;
            r_m_valid  <= 1'b0;
        end else begin
            if (cfg_write && paddr[2] == REG_SYNC_BYTE) begin
                r_sync <= pwdata[7:0];
            end
            if (s_fire) begin
                r_pos      <= n_pos;
                r_rejected <= n_rejected;
                r_ovf      <= n_ovf;
                r_rx_ver   <= n_rx_ver;
                r_ex_ver   <= n_ex_ver;
                r_if_ver   <= n_if_ver;
                r_power    <= n_power;
                r_m_valid  <= n_res_valid;
            end else if (m_axis_tready) begin
                r_m_valid  <= 1'b0;
            end
        end
    end

    // payload registers, always written before being read within a frame
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_shift <= n_shift;
            if (n_ctrl_we && eff_pos != POS_LAST_HDR) begin
                r_ctrl[eff_pos[1:0] - 2'd3] <= b;
            end
            if (n_res_valid) begin
                r_m_kind <= n_res_kind;
                r_m_data <= n_res_data;
            end
        end
    end

endmodule

>>> tb/iq_frame_deframer_unit_test.sv
`timescale 1ns / 1ps

module iq_frame_deframer_unit_test;
    import iqdf_pkg::*;

    localparam int GROUPS       = GROUPS_DEFAULT;
    localparam int FRAME_LEN    = HEADER_BYTES + GROUP_BYTES * GROUPS;
    localparam int LIMIT_CYCLES = 1_500_000;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS  = 10;

    localparam logic [2:0] ADDR_SYNC  = {REG_SYNC_BYTE, 2'b00};
    localparam logic [2:0] ADDR_SPARE = 3'd4;    // index 1, not a register

    typedef struct {
        logic [1:0] kind;
        t_result    res;
    } t_deframed;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [2:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    iq_frame_deframer_unit #(
        .GROUPS_PER_FRAME(GROUPS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // predicted deframer state
    int unsigned frame_pos;
    bit          hunting;
    logic [7:0]  ctl_bytes [5];
    logic [55:0] sample_window;
    bit          ovf_sticky;
    logic [7:0]  ver_bytes [3];
    logic [15:0] power_word;
    logic [7:0]  sync_value;

    t_deframed pending_results[$];
    int        live_items;
    int        mismatches;
    int        cycles;
    bit        src_gaps_on;
    bit        sink_stalls_on;
    int        stall_left;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // advances the predicted state by one request, returns 1 when a result is due
    function automatic bit deframe_predict(input logic kind, input logic [7:0] b,
                                           input logic fs, output t_deframed e);
        int unsigned p;
        bit due;
        e.kind = RES_SAMPLES;
        e.res  = '0;
        due    = 1'b0;
        if (kind == IN_OVF_READ) begin
            e.kind             = RES_OVF_READ;
            e.res.adc_overflow = ovf_sticky;
            ovf_sticky         = 1'b0;
            live_items++;
            return 1'b1;
        end
        if (fs) begin
            frame_pos = 0;
            hunting   = 1'b0;
        end
        if (hunting) return 1'b0;
        live_items++;
        p = frame_pos;
        if (p < SYNC_BYTES) begin
            if (b != sync_value) begin
                e.kind    = RES_SYNC_ERR;
                hunting   = 1'b1;
                frame_pos = 0;
                return 1'b1;
            end
        end else if (p < HEADER_BYTES) begin
            ctl_bytes[p - SYNC_BYTES] = b;
            if (p == HEADER_BYTES - 1) begin
                if (!ctl_bytes[0][C0_POWER_BIT]) begin
                    if (ctl_bytes[1][C1_OVF_BIT]) ovf_sticky = 1'b1;
                    ver_bytes[0] = ctl_bytes[2];
                end else begin
                    power_word = {ctl_bytes[1], ctl_bytes[2]};
                end
                ver_bytes[1]              = ctl_bytes[3];
                ver_bytes[2]              = ctl_bytes[4];
                e.kind                    = RES_CONTROL;
                e.res.ptt_dot             = ctl_bytes[0][C0_PTT_BIT];
                e.res.dash_key            = !ctl_bytes[0][C0_PTT_BIT]
                                            && ctl_bytes[0][C0_DASH_BIT];
                e.res.adc_overflow        = ovf_sticky;
                e.res.receiver_version    = ver_bytes[0];
                e.res.exciter_version     = ver_bytes[1];
                e.res.interface_version   = ver_bytes[2];
                e.res.fwd_power           = power_word;
                due                       = 1'b1;
            end
        end else begin
            if ((p - HEADER_BYTES) % GROUP_BYTES == GROUP_BYTES - 1) begin
                e.kind           = RES_SAMPLES;
                e.res.left_chan  = sample_window[55:32];
                e.res.right_chan = sample_window[31:8];
                e.res.mic_chan   = {sample_window[7:0], b};
                due              = 1'b1;
            end
            sample_window = {sample_window[47:0], b};
        end
        p++;
        if (p >= FRAME_LEN) begin
            hunting = 1'b1;
            p       = 0;
        end
        frame_pos = p;
        return due;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on %s: expected %h, got %h (cycle %0d)", what, want, got, cycles);
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) note_mismatch(what, want, got);
    endtask

    task automatic send_item(input logic kind, input logic [7:0] b, input logic fs);
        int gap;
        t_deframed e;
        gap = src_gaps_on ? pick_gap() : 0;
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tuser  = {fs, kind};
        do @(posedge i_clk); while (!s_axis_tready);
        if (deframe_predict(kind, b, fs, e)) pending_results.push_back(e);
    endtask

    // lets every outstanding result drain before touching the register
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [7:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = {24'h0, val};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_SYNC) sync_value = val;
        // read back in the following transfer
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_SYNC) check_field("sync_byte read", {24'h0, val}, {24'h0, prdata[7:0]});
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // len bytes from a frame start; bytes past the frame end are ignored by the block
    task automatic send_frame(input int len, input bit corrupt);
        int bad_at;
        logic [7:0] b;
        bad_at = corrupt ? $urandom_range(0, SYNC_BYTES - 1) : -1;
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) send_item(IN_DATA_BYTE, 8'($urandom), 1'b0);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 3)
                send_item(IN_OVF_READ, 8'($urandom), 1'($urandom));
            if (i < SYNC_BYTES) begin
                b = (i == bad_at) ? sync_value ^ 8'($urandom_range(1, 255)) : sync_value;
            end else if (i < HEADER_BYTES) begin
                b = 8'($urandom);
            end else begin
                case ($urandom_range(0, 7))
                    0: b = 8'h00;
                    1: b = 8'hFF;
                    2: b = 8'h7F;
                    3: b = 8'h80;
                    default: b = 8'($urandom);
                endcase
            end
            send_item(IN_DATA_BYTE, b, i == 0);
        end
    endtask

    // header decode with dash and overflow set, one group of extreme samples
    task automatic test_header_and_group();
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        send_item(IN_DATA_BYTE, 8'h55, 1'b0);   // ignored, no frame start yet
        send_item(IN_OVF_READ, 8'hFF, 1'b1);
        send_item(IN_DATA_BYTE, sync_value, 1'b1);
        send_item(IN_DATA_BYTE, sync_value, 1'b0);
        send_item(IN_DATA_BYTE, sync_value, 1'b0);
        send_item(IN_DATA_BYTE, 8'h02, 1'b0);
        send_item(IN_DATA_BYTE, 8'h01, 1'b0);
        send_item(IN_DATA_BYTE, 8'hAB, 1'b0);
        send_item(IN_DATA_BYTE, 8'h00, 1'b0);
        send_item(IN_DATA_BYTE, 8'hFF, 1'b0);
        send_item(IN_DATA_BYTE, 8'h7F, 1'b0);
        send_item(IN_DATA_BYTE, 8'hFF, 1'b0);
        send_item(IN_DATA_BYTE, 8'hFF, 1'b0);
        send_item(IN_DATA_BYTE, 8'h80, 1'b0);
        send_item(IN_DATA_BYTE, 8'h00, 1'b0);
        send_item(IN_DATA_BYTE, 8'h00, 1'b0);
        send_item(IN_DATA_BYTE, 8'h80, 1'b0);
        send_item(IN_DATA_BYTE, 8'h00, 1'b0);
        send_item(IN_OVF_READ, 8'h00, 1'b0);
    endtask

    // frame start in mid frame, then the forward power path with ptt
    task automatic test_restart_and_power();
        send_item(IN_DATA_BYTE, sync_value, 1'b1);
        send_item(IN_DATA_BYTE, sync_value, 1'b0);
        send_item(IN_DATA_BYTE, sync_value, 1'b0);
        send_item(IN_DATA_BYTE, 8'h07, 1'b0);
        send_item(IN_DATA_BYTE, 8'h80, 1'b0);
        send_item(IN_DATA_BYTE, 8'h01, 1'b0);
        send_item(IN_DATA_BYTE, 8'h5A, 1'b0);
        send_item(IN_DATA_BYTE, 8'hA5, 1'b0);
    endtask

    task automatic test_sync_error();
        send_item(IN_DATA_BYTE, sync_value, 1'b1);
        send_item(IN_DATA_BYTE, ~sync_value, 1'b0);
        send_item(IN_DATA_BYTE, 8'h00, 1'b0);   // dropped while hunting
    endtask

    // a write to an unused address must leave the sync byte alone
    task automatic test_spare_register();
        wait_idle();
        write_reg(ADDR_SPARE, ~sync_value);
        send_frame(HEADER_BYTES + GROUP_BYTES, 1'b0);
    endtask

    task automatic test_random_frames(input logic [7:0] sync_val, input int count,
                                      input bit lead_full);
        int stop;
        int len;
        wait_idle();
        write_reg(ADDR_SYNC, sync_val);
        stop = live_items + count;
        if (lead_full) send_frame(FRAME_LEN + $urandom_range(1, 4), 1'b0);
        while (live_items < stop) begin
            src_gaps_on    = 1'($urandom_range(0, 1));
            sink_stalls_on = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 39) == 0)
                len = FRAME_LEN + $urandom_range(0, 4);
            else
                len = $urandom_range(1, HEADER_BYTES + GROUP_BYTES * 4 + 3);
            send_frame(len, $urandom_range(0, 9) == 0);
        end
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready = 1'b0;
            stall_left--;
        end else begin
            stall_left    = sink_stalls_on ? pick_gap() : 0;
            m_axis_tready = (stall_left == 0);
            if (stall_left > 0) stall_left--;
        end
    end

    always @(posedge i_clk) begin
        t_deframed want;
        t_result   got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result kind", 32'h0, {30'h0, m_axis_tuser});
            end else begin
                want = pending_results.pop_front();
                got  = m_axis_tdata[$bits(t_result)-1:0];
                check_field("result_kind", 32'(want.kind), 32'(m_axis_tuser));
                check_field("left_chan", 32'(want.res.left_chan), 32'(got.left_chan));
                check_field("right_chan", 32'(want.res.right_chan), 32'(got.right_chan));
                check_field("mic_chan", 32'(want.res.mic_chan), 32'(got.mic_chan));
                check_field("ptt_dot", 32'(want.res.ptt_dot), 32'(got.ptt_dot));
                check_field("dash_key", 32'(want.res.dash_key), 32'(got.dash_key));
                check_field("adc_overflow", 32'(want.res.adc_overflow),
                            32'(got.adc_overflow));
                check_field("receiver_version", 32'(want.res.receiver_version),
                            32'(got.receiver_version));
                check_field("exciter_version", 32'(want.res.exciter_version),
                            32'(got.exciter_version));
                check_field("interface_version", 32'(want.res.interface_version),
                            32'(got.interface_version));
                check_field("fwd_power", 32'(want.res.fwd_power), 32'(got.fwd_power));
                check_field("tdata padding", 32'h0,
                            32'(m_axis_tdata[OUT_DATA_W-1:$bits(t_result)]));
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = 8'h00;
        s_axis_tuser   = 2'b00;
        m_axis_tready  = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = 3'd0;
        pwdata         = 32'h0;
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        stall_left     = 0;
        cycles         = 0;
        mismatches     = 0;
        live_items     = 0;
        frame_pos      = 0;
        hunting        = 1'b1;
        sample_window  = '0;
        ovf_sticky     = 1'b0;
        power_word     = '0;
        sync_value     = SYNC_RESET;
        foreach (ctl_bytes[i]) ctl_bytes[i] = '0;
        foreach (ver_bytes[i]) ver_bytes[i] = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_header_and_group();
        test_restart_and_power();
        test_sync_error();
        test_random_frames(8'h00, 475, 1'b1);
        test_spare_register();
        test_random_frames(8'hFF, 475, 1'b0);
        test_random_frames(8'($urandom_range(1, 254)), 475, 1'b0);
        test_random_frames(SYNC_RESET, 475, 1'b0);

        wait_idle();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
